@@ sv/lli_pkg.sv @@
// shared widths and sideband type for the line intersection pipeline
`timescale 1ns / 1ps

package lli_pkg;

  localparam int IN_W       = 31;  // coordinate input width
  localparam int OUT_W      = 32;  // coordinate result width
  localparam int DIF_W      = 32;  // point difference width
  localparam int PP_W       = 62;  // point cross product width
  localparam int C_W        = 63;  // line constant x1*y2 - y1*x2 width
  localparam int DEN_W      = 65;  // determinant width
  localparam int NUM_W      = 96;  // numerator width
  localparam int REM_W      = 97;  // divider remainder width
  localparam int Q_W        = 32;  // unsaturated quotient width
  localparam int DIV_STAGES = Q_W; // one quotient bit per stage

  // per item flags that ride along the divider
  typedef struct packed {
    logic par;    // determinant is zero
    logic neg_x;  // latitude quotient is negative
    logic neg_y;  // longitude quotient is negative
    logic big_x;  // latitude quotient magnitude at least 2^32
    logic big_y;  // longitude magnitude at least 2^32
  } lli_side_t;

endpackage

@@ sv/line_line_intersection.sv @@
// intersection of two lines given by point pairs, two-point determinant form
// pipeline from request accept to result: 7 arithmetic stages, 32 divider
//   stages with one quotient bit each, and one output register
// throughput: one request per cycle; the whole pipeline holds while a result
//   waits on m_axis_tready
// reset: asynchronous, active low, clears all valid bits; no other state
`timescale 1ns / 1ps

module line_line_intersection (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_start_lat, a_start_lon, a_end_lat, a_end_lon,
  // b_start_lat, b_start_lon, b_end_lat, b_end_lon (31 bits each)
  input  logic [247:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cross_lat [31:0], cross_lon [63:32]
  output logic [63:0]  m_axis_tdata,
  // parallel [0], overflow [1]
  output logic [1:0]   m_axis_tuser
);

  localparam int IN_W  = lli_pkg::IN_W;
  localparam int DIF_W = lli_pkg::DIF_W;
  localparam int PP_W  = lli_pkg::PP_W;
  localparam int C_W   = lli_pkg::C_W;
  localparam int DEN_W = lli_pkg::DEN_W;
  localparam int NUM_W = lli_pkg::NUM_W;
  localparam int REM_W = lli_pkg::REM_W;
  localparam int Q_W   = lli_pkg::Q_W;
  localparam int OUT_W = lli_pkg::OUT_W;
  localparam int HALF  = 32;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, out_v_q;

  logic signed [IN_W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;

  // stage 1
  logic signed [DIF_W-1:0] dxa1_q, dya1_q, dxb1_q, dyb1_q;
  logic signed [PP_W-1:0]  p12_q, p21_q, p34_q, p43_q;
  // stage 2
  logic signed [DIF_W-1:0] dxa2_q, dya2_q, dxb2_q, dyb2_q;
  logic signed [C_W-1:0]   ca_q, cb_q;
  logic signed [63:0]      dd1_q, dd2_q;
  // stage 3
  logic signed [DEN_W-1:0] den3_q;
  logic signed [HALF:0]    ca_lo, cb_lo;
  logic signed [C_W-HALF-1:0] ca_hi, cb_hi;
  logic signed [HALF+DIF_W:0]   ca_lo_dxb_q, ca_lo_dyb_q, cb_lo_dxa_q, cb_lo_dya_q;
  logic signed [C_W-HALF+DIF_W-1:0] ca_hi_dxb_q, ca_hi_dyb_q, cb_hi_dxa_q, cb_hi_dya_q;
  // stage 4
  logic signed [DEN_W-1:0] den4_q;
  logic signed [NUM_W-1:0] t1_q, t2_q, t3_q, t4_q;
  // stage 5
  logic signed [DEN_W-1:0] den5_q;
  logic signed [NUM_W-1:0] nx5_q, ny5_q;
  // stage 6
  logic [NUM_W-1:0] ax6_q, ay6_q;
  logic [DEN_W-1:0] ad6_q;
  logic             neg_x6_q, neg_y6_q, par6_q;
  // stage 7
  logic [NUM_W-1:0]   ax7_q, ay7_q;
  logic [DEN_W-1:0]   ad7_q;
  logic [REM_W-1:0]   lim;
  lli_pkg::lli_side_t side7_q;

  // divider outputs
  logic               dv;
  logic [Q_W-1:0]     q_x, q_y;
  lli_pkg::lli_side_t dside;

  logic [OUT_W-1:0] lat_d, lon_d, lat_q, lon_q;
  logic             ovx, ovy, par_q, ovf_q;

  // pipeline advances when the output register is free or being drained
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  assign x1 = s_axis_tdata[30:0];
  assign y1 = s_axis_tdata[61:31];
  assign x2 = s_axis_tdata[92:62];
  assign y2 = s_axis_tdata[123:93];
  assign x3 = s_axis_tdata[154:124];
  assign y3 = s_axis_tdata[185:155];
  assign x4 = s_axis_tdata[216:186];
  assign y4 = s_axis_tdata[247:217];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      v7_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= s_axis_tvalid;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      v7_q    <= v6_q;
      out_v_q <= dv;
    end
  end

  // split line constants into unsigned low and signed high halves
  assign ca_lo = signed'({1'b0, ca_q[HALF-1:0]});
  assign cb_lo = signed'({1'b0, cb_q[HALF-1:0]});
  assign ca_hi = ca_q[C_W-1:HALF];
  assign cb_hi = cb_q[C_W-1:HALF];

  // saturation bound for the early overflow check
  assign lim = REM_W'(ad6_q) << HALF;

  // arithmetic stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      // differences and point cross products
      dxa1_q <= DIF_W'(x1) - DIF_W'(x2);
      dya1_q <= DIF_W'(y1) - DIF_W'(y2);
      dxb1_q <= DIF_W'(x3) - DIF_W'(x4);
      dyb1_q <= DIF_W'(y3) - DIF_W'(y4);
      p12_q  <= PP_W'(x1) * PP_W'(y2);
      p21_q  <= PP_W'(y1) * PP_W'(x2);
      p34_q  <= PP_W'(x3) * PP_W'(y4);
      p43_q  <= PP_W'(y3) * PP_W'(x4);
      // line constants and determinant products
      dxa2_q <= dxa1_q;
      dya2_q <= dya1_q;
      dxb2_q <= dxb1_q;
      dyb2_q <= dyb1_q;
      ca_q   <= C_W'(p12_q) - C_W'(p21_q);
      cb_q   <= C_W'(p34_q) - C_W'(p43_q);
      dd1_q  <= 64'(dxa1_q) * 64'(dyb1_q);
      dd2_q  <= 64'(dya1_q) * 64'(dxb1_q);
      // determinant and partial products of the numerators
      den3_q      <= DEN_W'(dd1_q) - DEN_W'(dd2_q);
      ca_lo_dxb_q <= (HALF+DIF_W+1)'(ca_lo) * (HALF+DIF_W+1)'(dxb2_q);
      ca_lo_dyb_q <= (HALF+DIF_W+1)'(ca_lo) * (HALF+DIF_W+1)'(dyb2_q);
      cb_lo_dxa_q <= (HALF+DIF_W+1)'(cb_lo) * (HALF+DIF_W+1)'(dxa2_q);
      cb_lo_dya_q <= (HALF+DIF_W+1)'(cb_lo) * (HALF+DIF_W+1)'(dya2_q);
      ca_hi_dxb_q <= (C_W-HALF+DIF_W)'(ca_hi) * (C_W-HALF+DIF_W)'(dxb2_q);
      ca_hi_dyb_q <= (C_W-HALF+DIF_W)'(ca_hi) * (C_W-HALF+DIF_W)'(dyb2_q);
      cb_hi_dxa_q <= (C_W-HALF+DIF_W)'(cb_hi) * (C_W-HALF+DIF_W)'(dxa2_q);
      cb_hi_dya_q <= (C_W-HALF+DIF_W)'(cb_hi) * (C_W-HALF+DIF_W)'(dya2_q);
      // combine partial products
      den4_q <= den3_q;
      t1_q   <= (NUM_W'(ca_hi_dxb_q) <<< HALF) + NUM_W'(ca_lo_dxb_q);
      t2_q   <= (NUM_W'(cb_hi_dxa_q) <<< HALF) + NUM_W'(cb_lo_dxa_q);
      t3_q   <= (NUM_W'(ca_hi_dyb_q) <<< HALF) + NUM_W'(ca_lo_dyb_q);
      t4_q   <= (NUM_W'(cb_hi_dya_q) <<< HALF) + NUM_W'(cb_lo_dya_q);
      // numerators
      den5_q <= den4_q;
      nx5_q  <= t1_q - t2_q;
      ny5_q  <= t3_q - t4_q;
      // magnitudes and quotient signs
      ax6_q    <= nx5_q[NUM_W-1] ? NUM_W'(-nx5_q) : NUM_W'(nx5_q);
      ay6_q    <= ny5_q[NUM_W-1] ? NUM_W'(-ny5_q) : NUM_W'(ny5_q);
      ad6_q    <= den5_q[DEN_W-1] ? DEN_W'(-den5_q) : DEN_W'(den5_q);
      neg_x6_q <= nx5_q[NUM_W-1] ^ den5_q[DEN_W-1];
      neg_y6_q <= ny5_q[NUM_W-1] ^ den5_q[DEN_W-1];
      par6_q   <= den5_q == '0;
      // early overflow check against divisor times 2^32
      ax7_q         <= ax6_q;
      ay7_q         <= ay6_q;
      ad7_q         <= ad6_q;
      side7_q.par   <= par6_q;
      side7_q.neg_x <= neg_x6_q;
      side7_q.neg_y <= neg_y6_q;
      side7_q.big_x <= REM_W'(ax6_q) >= lim;
      side7_q.big_y <= REM_W'(ay6_q) >= lim;
    end
  end

  lli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_x_i (ax7_q),
    .num_y_i (ay7_q),
    .den_i   (ad7_q),
    .side_i  (side7_q),
    .valid_o (dv),
    .q_x_o   (q_x),
    .q_y_o   (q_y),
    .side_o  (dside)
  );

  // signed, saturated coordinate from magnitude quotient
  function automatic logic [OUT_W:0] fix_coord(input logic [Q_W-1:0] q,
                                               input logic neg, input logic big);
    logic [OUT_W-1:0] pos_max, neg_min;
    pos_max = {1'b0, {(OUT_W-1){1'b1}}};
    neg_min = {1'b1, {(OUT_W-1){1'b0}}};
    if (!neg) begin
      if (big || OUT_W'(q) > pos_max) fix_coord = {1'b1, pos_max};
      else                             fix_coord = {1'b0, OUT_W'(q)};
    end else begin
      if (big || OUT_W'(q) > neg_min) fix_coord = {1'b1, neg_min};
      else                             fix_coord = {1'b0, OUT_W'(-OUT_W'(q))};
    end
  endfunction

  // output formatting
  always_comb begin
    {ovx, lat_d} = fix_coord(q_x, dside.neg_x, dside.big_x);
    {ovy, lon_d} = fix_coord(q_y, dside.neg_y, dside.big_y);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat_q <= dside.par ? '0 : lat_d;
      lon_q <= dside.par ? '0 : lon_d;
      par_q <= dside.par;
      ovf_q <= !dside.par && (ovx || ovy);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {lon_q, lat_q};
  assign m_axis_tuser  = {ovf_q, par_q};

  // parallel results carry the zero position and no overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && par_q |-> lat_q == '0 && lon_q == '0 && !ovf_q)
    else $error("parallel result not cleared");

  // overflow means at least one coordinate sits at a bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && ovf_q |-> lat_q == 32'h7FFF_FFFF || lat_q == 32'h8000_0000 ||
                         lon_q == 32'h7FFF_FFFF || lon_q == 32'h8000_0000)
    else $error("overflow without saturated coordinate");

  // a held pipeline keeps its front stages
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v1_q) && $stable(v7_q))
    else $error("pipeline moved while held");

endmodule

@@ sv/lli_div.sv @@
// pipelined restoring divider, two quotients per item, one bit per stage
`timescale 1ns / 1ps

module lli_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [lli_pkg::NUM_W-1:0] num_x_i,
  input  logic [lli_pkg::NUM_W-1:0] num_y_i,
  input  logic [lli_pkg::DEN_W-1:0] den_i,
  input  lli_pkg::lli_side_t        side_i,
  output logic                      valid_o,
  output logic [lli_pkg::Q_W-1:0]   q_x_o,
  output logic [lli_pkg::Q_W-1:0]   q_y_o,
  output lli_pkg::lli_side_t        side_o
);

  localparam int NS = lli_pkg::DIV_STAGES;

  logic                      v_q    [NS];
  logic [lli_pkg::REM_W-1:0] rx_q   [NS];
  logic [lli_pkg::REM_W-1:0] ry_q   [NS];
  logic [lli_pkg::Q_W-1:0]   qx_q   [NS];
  logic [lli_pkg::Q_W-1:0]   qy_q   [NS];
  logic [lli_pkg::DEN_W-1:0] d_q    [NS];
  lli_pkg::lli_side_t        side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int SH = NS - 1 - k;
    logic                      v_in;
    logic [lli_pkg::REM_W-1:0] rx_in, ry_in, trial;
    logic [lli_pkg::Q_W-1:0]   qx_in, qy_in;
    logic [lli_pkg::DEN_W-1:0] d_in;
    lli_pkg::lli_side_t        side_in;
    logic                      ge_x, ge_y;

    // stage source: the inputs or the stage before
    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rx_in   = lli_pkg::REM_W'(num_x_i);
      assign ry_in   = lli_pkg::REM_W'(num_y_i);
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign d_in    = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rx_in   = rx_q[k-1];
      assign ry_in   = ry_q[k-1];
      assign qx_in   = qx_q[k-1];
      assign qy_in   = qy_q[k-1];
      assign d_in    = d_q[k-1];
      assign side_in = side_q[k-1];
    end

    // trial subtract of the shifted divisor
    assign trial = lli_pkg::REM_W'(d_in) << SH;
    assign ge_x  = rx_in >= trial;
    assign ge_y  = ry_in >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[k]   <= ge_x ? rx_in - trial : rx_in;
        ry_q[k]   <= ge_y ? ry_in - trial : ry_in;
        qx_q[k]   <= {qx_in[lli_pkg::Q_W-2:0], ge_x};
        qy_q[k]   <= {qy_in[lli_pkg::Q_W-2:0], ge_y};
        d_q[k]    <= d_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign q_x_o   = qx_q[NS-1];
  assign q_y_o   = qy_q[NS-1];
  assign side_o  = side_q[NS-1];

  // the final remainder stays below the divisor unless saturating anyway or parallel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && !side_q[NS-1].big_x && !side_q[NS-1].par
      |-> rx_q[NS-1] < lli_pkg::REM_W'(d_q[NS-1]))
    else $error("lli_div: latitude remainder not reduced");

  // a held pipeline keeps its last stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(v_q[NS-1]) && $stable(qx_q[NS-1]))
    else $error("lli_div: last stage moved while held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && !side_q[NS-1].big_y && !side_q[NS-1].par
      |-> ry_q[NS-1] < lli_pkg::REM_W'(d_q[NS-1]))
    else $error("lli_div: longitude remainder not reduced");

endmodule

@@ dv/line_line_intersection_tb.sv @@
// testbench for the line intersection block with directed and random line pairs
`timescale 1ns / 1ps

module line_line_intersection_tb;

  localparam int  IN_W        = lli_pkg::IN_W;
  localparam int  OUT_W       = lli_pkg::OUT_W;
  localparam int  TOTAL_ITEMS = 1600;
  localparam int  LATENCY     = 40;
  localparam longint MAX_CYC  = 200000;
  localparam int  CMAX        = 754974720;

  typedef struct {
    logic [OUT_W-1:0] lat;
    logic [OUT_W-1:0] lon;
    logic             par;
    logic             ovf;
  } cross_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [247:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  line_line_intersection i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  logic [247:0] pending_requests [$];
  cross_t       expected_crossings [$];
  int           n_errors = 0;
  int           n_sent = 0;
  int           n_checked = 0;
  int           n_parallel = 0;
  int           n_saturated = 0;
  longint       cycle_count = 0;
  bit           hold_sender = 0;
  int           send_wait = 0;
  int           recv_wait = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // saturate a truncated quotient to 32 bits
  function automatic logic [OUT_W-1:0] sat_quotient(logic signed [127:0] n,
      logic signed [127:0] d, ref bit ovf);
    logic signed [127:0] q;
    begin
      q = n / d;
      if (q > 128'sd2147483647) begin
        ovf = 1;
        return 32'h7fffffff;
      end
      if (q < -128'sd2147483648) begin
        ovf = 1;
        return 32'h80000000;
      end
      return q[OUT_W-1:0];
    end
  endfunction

  // exact intersection from the determinant form
  function automatic cross_t predict_crossing(logic [247:0] req);
    logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
    logic signed [127:0] dxa, dya, dxb, dyb, den, ca, cb;
    cross_t r;
    bit ovf;
    begin
      x1 = $signed(req[0*IN_W +: IN_W]);
      y1 = $signed(req[1*IN_W +: IN_W]);
      x2 = $signed(req[2*IN_W +: IN_W]);
      y2 = $signed(req[3*IN_W +: IN_W]);
      x3 = $signed(req[4*IN_W +: IN_W]);
      y3 = $signed(req[5*IN_W +: IN_W]);
      x4 = $signed(req[6*IN_W +: IN_W]);
      y4 = $signed(req[7*IN_W +: IN_W]);
      dxa = x1 - x2;
      dya = y1 - y2;
      dxb = x3 - x4;
      dyb = y3 - y4;
      den = dxa * dyb - dya * dxb;
      ovf = 0;
      if (den == 0) begin
        r.lat = '0;
        r.lon = '0;
        r.par = 1'b1;
        r.ovf = 1'b0;
      end else begin
        ca = x1 * y2 - y1 * x2;
        cb = x3 * y4 - y3 * x4;
        r.lat = sat_quotient(ca * dxb - dxa * cb, den, ovf);
        r.lon = sat_quotient(ca * dyb - dya * cb, den, ovf);
        r.par = 1'b0;
        r.ovf = ovf;
      end
      return r;
    end
  endfunction

  function automatic logic [IN_W-1:0] rand_coord(int mode);
    begin
      case (mode)
        0: return IN_W'($urandom);
        1: return IN_W'($urandom_range(2 * CMAX) - CMAX);
        2: return IN_W'($urandom_range(2000) - 1000);
        default: return IN_W'($urandom_range(1 << 20) - (1 << 19));
      endcase
    end
  endfunction

  function automatic logic [247:0] pack_pair(logic [IN_W-1:0] x1, y1, x2, y2,
      x3, y3, x4, y4);
    return {y4, x4, y3, x3, y2, x2, y1, x1};
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_wait     <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_crossings.push_back(predict_crossing(s_axis_tdata));
        n_sent <= n_sent + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_wait > 0) begin
          s_axis_tvalid <= 1'b0;
          send_wait     <= send_wait - 1;
        end else if (pending_requests.size() > 0 && !hold_sender) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_requests.pop_front();
          send_wait     <= ($urandom_range(3) == 0) ? 0 : $urandom_range(3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    cross_t e;
    int errs;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait     <= 0;
    end else begin
      errs = 0;
      if (m_axis_tvalid && m_axis_tready) begin
        n_checked <= n_checked + 1;
        if (expected_crossings.size() == 0) begin
          $display("%0t: unexpected result lat %h lon %h user %b", $time,
                   m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
          errs++;
        end else begin
          e = expected_crossings.pop_front();
          if (e.par) n_parallel <= n_parallel + 1;
          if (e.ovf) n_saturated <= n_saturated + 1;
          if (m_axis_tdata[31:0] !== e.lat) begin
            $display("%0t: cross_lat expected %h actual %h", $time, e.lat,
                     m_axis_tdata[31:0]);
            errs++;
          end
          if (m_axis_tdata[63:32] !== e.lon) begin
            $display("%0t: cross_lon expected %h actual %h", $time, e.lon,
                     m_axis_tdata[63:32]);
            errs++;
          end
          if (m_axis_tuser[0] !== e.par) begin
            $display("%0t: parallel expected %b actual %b", $time, e.par,
                     m_axis_tuser[0]);
            errs++;
          end
          if (m_axis_tuser[1] !== e.ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, e.ovf,
                     m_axis_tuser[1]);
            errs++;
          end
        end
      end
      if (errs > 0) n_errors <= n_errors + errs;
      if (recv_wait > 0) begin
        m_axis_tready <= 1'b0;
        recv_wait     <= recv_wait - 1;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid && m_axis_tready)
          recv_wait <= ($urandom_range(3) == 0) ? 0 : $urandom_range(3);
      end
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYC) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_crossings.size());
      $display("line_line_intersection_tb NOT OK");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [IN_W-1:0] mx, mn, v[8];
    int mode, k;
    mx = IN_W'(CMAX);
    mn = IN_W'(-CMAX);
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: simple cross, extremes, parallel, degenerate, saturation
    pending_requests.push_back(pack_pair(0, 0, 100, 100, 0, 100, 100, 0));
    pending_requests.push_back(pack_pair(mn, mn, mx, mx, mn, mx, mx, mn));
    pending_requests.push_back(pack_pair(mx, mn, mn, mx, mx, mx, mn, mn));
    pending_requests.push_back(pack_pair(0, 0, 10, 10, 1, 0, 11, 10));
    pending_requests.push_back(pack_pair(5, 5, 5, 5, 1, 2, 3, 4));
    pending_requests.push_back(pack_pair(5, 5, 5, 5, 7, 7, 7, 7));
    pending_requests.push_back(pack_pair(mx, mx, mx, mx, mn, mn, mn, mn));
    pending_requests.push_back(pack_pair(0, 0, mx, 1, 0, 1, mx, 2));
    pending_requests.push_back(pack_pair(0, 0, mx, 1, 0, mx, mx, mx - 31'd1));
    pending_requests.push_back(pack_pair(mn, 0, mx, 1, mn, 1, mx, 3));
    pending_requests.push_back(pack_pair(0, mn, 1, mx, 3, mn, 5, mx));
    pending_requests.push_back(pack_pair('1, '1, 31'h3fffffff, 31'h40000000,
                                         31'h40000000, 31'h3fffffff, 0, '1));
    pending_requests.push_back(pack_pair(31'h40000000, 31'h40000000, 31'h3fffffff,
                                         31'h3fffffff, 0, 1, 1, 0));
    pending_requests.push_back(pack_pair(31'h7fffffff, 31'h55555555, 31'h2aaaaaaa,
                                         31'h00000000, 31'h12345678, 31'h6edcba98,
                                         31'h40000001, 31'h3ffffffe));
    pending_requests.push_back(pack_pair(-3, 7, 9, -2, -3, -8, 4, 11));

    // let the directed part drain, then random traffic
    while (pending_requests.size() > 0 || expected_crossings.size() > 0 ||
           s_axis_tvalid)
      @(posedge clk_i);

    for (int i = 0; i < TOTAL_ITEMS; i++) begin
      mode = $urandom_range(3);
      for (k = 0; k < 8; k++) v[k] = rand_coord(mode);
      case ($urandom_range(9))
        // parallel: second line shifted copy of the first
        0: begin
          v[4] = v[0] + 31'($urandom_range(50));
          v[5] = v[1] - 31'($urandom_range(50));
          v[6] = v[4] + (v[2] - v[0]);
          v[7] = v[5] + (v[3] - v[1]);
        end
        // degenerate line
        1: begin
          v[6] = v[4];
          v[7] = v[5];
        end
        // nearly parallel, drives saturation
        2: begin
          v[4] = v[0] + 31'($urandom_range(1000));
          v[5] = v[1];
          v[6] = v[4] + (v[2] - v[0]) + 31'($urandom_range(1));
          v[7] = v[5] + (v[3] - v[1]) + 31'($urandom_range(1));
        end
        default: ;
      endcase
      pending_requests.push_back(pack_pair(v[0], v[1], v[2], v[3], v[4], v[5],
                                           v[6], v[7]));
      // sender holds off until the pipeline drains
      if (i == TOTAL_ITEMS / 2) begin
        while (pending_requests.size() > 0 || s_axis_tvalid) @(posedge clk_i);
        hold_sender = 1;
        while (expected_crossings.size() > 0) @(posedge clk_i);
        hold_sender = 0;
      end
    end

    while (pending_requests.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_crossings.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("sent %0d line pairs, checked %0d results (%0d parallel, %0d saturated)",
             n_sent, n_checked, n_parallel, n_saturated);
    if (n_errors == 0 && expected_crossings.size() == 0) begin
      $display("line_line_intersection_tb OK");
    end else begin
      $display("line_line_intersection_tb NOT OK");
    end
    $finish;
  end

endmodule
